// ----- rtl/keypad_scan_debouncer_assert.svh -----
// ----------------------------------------------------------------------------
// keypad_scan_debouncer_assert.svh
// Assertion macros used by the keypad debouncer checker.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_DEBOUNCER_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define KSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad debouncer check failed");

// Next-cycle implication, disabled while in reset.
`define KSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad debouncer check failed");

`endif

// ----- rtl/kpd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types, phase codes and the scan code table of the keypad debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

    localparam int KEY_COUNT = 16;
    localparam int KEY_W     = 5;
    localparam int CODE_W    = 8;
    localparam int TICKS_W   = 8;
    localparam int PHASE_W   = 2;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd30;
    localparam logic [CODE_W-1:0]  CODE_NONE   = 8'hff;

    localparam logic [PHASE_W-1:0] PH_RELEASED = 2'd0;
    localparam logic [PHASE_W-1:0] PH_UNKNOWN  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PUSHED   = 2'd2;

    localparam logic [CODE_W-1:0] CODE_TABLE [KEY_COUNT] = '{
        8'hee, 8'hed, 8'heb, 8'hde, 8'hdd, 8'hdb, 8'hbe, 8'hbd,
        8'hbb, 8'he7, 8'hd7, 8'hb7, 8'h77, 8'h7e, 8'h7b, 8'h7d
    };

    typedef struct packed {
        logic                 key_event;
        logic [KEY_W-1:0]     key_number;
        logic [PHASE_W-1:0]   phase;
    } step_result_t;

    // Key 1..16 for a table hit, 0 for no key or an unknown code.
    function automatic logic [KEY_W-1:0] decode_key(input logic [CODE_W-1:0] code);
        logic [KEY_W-1:0] key;
        key = '0;
        if (code != CODE_NONE)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                if (CODE_TABLE[i] == code)
                begin
                    key = KEY_W'(i + 1);
                end
            end
        end
        return key;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kpd_fsm.sv -----
// ----------------------------------------------------------------------------
// kpd_fsm
// Debounce state machine with hold-off countdown; advances once per step.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_fsm
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [kpd_pkg::KEY_W-1:0]   key,
    input  wire logic [kpd_pkg::TICKS_W-1:0] debounce_ticks,
    output kpd_pkg::step_result_t            result
);

    logic [kpd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [kpd_pkg::PHASE_W-1:0] prior_reg, prior_next;
    logic [kpd_pkg::KEY_W-1:0]   cand_reg, cand_next;
    logic                        waiting_reg, waiting_next;
    logic [kpd_pkg::TICKS_W-1:0] count_reg, count_next;
    logic [kpd_pkg::KEY_W-1:0]   report;
    logic [kpd_pkg::TICKS_W-1:0] count_dec;
    logic                        run;

    assign count_dec = count_reg - kpd_pkg::TICKS_W'(1);
    assign run       = !waiting_reg || (count_dec == '0);

    always_comb
    begin
        phase_next   = phase_reg;
        prior_next   = prior_reg;
        cand_next    = cand_reg;
        waiting_next = waiting_reg;
        count_next   = waiting_reg ? count_dec : count_reg;
        report       = '0;
        if (run)
        begin
            unique case (phase_reg)
                kpd_pkg::PH_RELEASED:
                begin
                    if (key != '0)
                    begin
                        phase_next   = kpd_pkg::PH_UNKNOWN;
                        prior_next   = kpd_pkg::PH_RELEASED;
                        waiting_next = 1'b1;
                        count_next   = debounce_ticks;
                        cand_next    = key;
                    end
                end
                kpd_pkg::PH_UNKNOWN:
                begin
                    if (key != '0)
                    begin
                        if (key == cand_reg)
                        begin
                            phase_next   = kpd_pkg::PH_PUSHED;
                            prior_next   = kpd_pkg::PH_UNKNOWN;
                            waiting_next = 1'b0;
                        end
                        else
                        begin
                            waiting_next = 1'b1;
                            count_next   = debounce_ticks;
                            cand_next    = key;
                        end
                    end
                    else
                    begin
                        phase_next = kpd_pkg::PH_RELEASED;
                        if (prior_reg == kpd_pkg::PH_PUSHED)
                        begin
                            report = cand_reg;
                        end
                        prior_next   = kpd_pkg::PH_UNKNOWN;
                        waiting_next = 1'b0;
                    end
                end
                kpd_pkg::PH_PUSHED:
                begin
                    if (key == '0)
                    begin
                        phase_next   = kpd_pkg::PH_UNKNOWN;
                        prior_next   = kpd_pkg::PH_PUSHED;
                        waiting_next = 1'b1;
                        count_next   = debounce_ticks;
                    end
                    else if (key != cand_reg)
                    begin
                        // held key reported, new key restarts as if from release
                        phase_next   = kpd_pkg::PH_UNKNOWN;
                        prior_next   = kpd_pkg::PH_RELEASED;
                        waiting_next = 1'b1;
                        count_next   = debounce_ticks;
                        report       = cand_reg;
                        cand_next    = key;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= kpd_pkg::PH_RELEASED;
            prior_reg   <= kpd_pkg::PH_RELEASED;
            cand_reg    <= '0;
            waiting_reg <= 1'b0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            prior_reg   <= prior_next;
            cand_reg    <= cand_next;
            waiting_reg <= waiting_next;
            count_reg   <= count_next;
        end
    end

    assign result.key_event  = (report != '0);
    assign result.key_number = report;
    assign result.phase      = phase_next;

endmodule

`default_nettype wire

// ----- rtl/keypad_scan_debouncer.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_debouncer
// Debounced 4x4 keypad scanner, one scan code item per timer tick.
// ----------------------------------------------------------------------------
// Each input item is one tick's scan code; each produces exactly one result
// item, registered in the cycle after it is accepted. The table match and
// state update are done in the cycle the item is accepted, so one item per
// clock is sustained; the only stall comes from the output register when the
// downstream side holds off tready. The user must write debounce_ticks through
// cfg_we/cfg_wdata only while idle, a rule the block leaves unchecked; 0 gives a 256-tick hold-off.
`default_nettype none

module keypad_scan_debouncer
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [kpd_pkg::TICKS_W-1:0] cfg_wdata,     // debounce_ticks
    input  wire logic                        s_axis_tvalid,
    output      logic                        s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // [7:0] scan_code
    output      logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output      logic [7:0]                  m_axis_tdata,  // [4:0] key_number, [6:5] debounce_phase
    output      logic                        m_axis_tuser   // key_event
);

    logic [kpd_pkg::TICKS_W-1:0] ticks_reg;
    logic                        out_valid_reg;
    kpd_pkg::step_result_t       out_reg;
    kpd_pkg::step_result_t       result;
    logic [kpd_pkg::KEY_W-1:0]   key;
    logic                        accept;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign key           = kpd_pkg::decode_key(s_axis_tdata);

    kpd_fsm u_fsm
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (accept),
        .key            (key),
        .debounce_ticks (ticks_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= kpd_pkg::TICKS_RESET;
        end
        else if (cfg_we)
        begin
            ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.key_event;
    assign m_axis_tdata  = {1'b0, out_reg.phase, out_reg.key_number};

endmodule

`default_nettype wire

// ----- rtl/kpd_checker.sv -----
// ----------------------------------------------------------------------------
// kpd_checker
// Port-level checks of the keypad debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keypad_scan_debouncer_assert.svh"

module kpd_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tuser
);

    `KSD_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `KSD_ASSERT_NEXT(a_one_cycle, clk, rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    `KSD_ASSERT_IMPL(a_event_key, clk, rst_n, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[4:0] != 5'd0) && (m_axis_tdata[4:0] <= 5'd16))
    `KSD_ASSERT_IMPL(a_no_event_key, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[4:0] == 5'd0)

endmodule

bind keypad_scan_debouncer kpd_checker u_kpd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/keypad_scan_debouncer_tb.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_debouncer_tb
// Streams keypad scan codes into the debouncer and checks every result item
// against an in-bench debounce predictor. Runs randomized keystrokes with
// bounce noise over several hold-off lengths, including the shortest, the
// longest and the 256-tick wrap, and directed key sequences at the shortest,
// with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module keypad_scan_debouncer_tb;

    localparam int CYCLE_LIMIT = 300000;

    localparam logic [kpd_pkg::CODE_W-1:0] DIRECTED [20] = '{
        8'h00, 8'hff, 8'hee, 8'hee, 8'hed, 8'hed, 8'hff, 8'hed, 8'hff, 8'hff,
        8'h7d, 8'h7e, 8'h7e, 8'h7d, 8'hff, 8'hef, 8'h7d, 8'h7d, 8'hff, 8'hff
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [kpd_pkg::TICKS_W-1:0]   cfg_wdata = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [7:0]                    m_axis_tdata;
    logic                          m_axis_tuser;

    // predictor state
    logic [kpd_pkg::PHASE_W-1:0]   ph = kpd_pkg::PH_RELEASED;
    logic [kpd_pkg::PHASE_W-1:0]   prior_ph = kpd_pkg::PH_RELEASED;
    logic [kpd_pkg::KEY_W-1:0]     cand_key = '0;
    logic                          hold_on = 1'b0;
    logic [kpd_pkg::TICKS_W-1:0]   hold_cnt = '0;
    logic [kpd_pkg::TICKS_W-1:0]   ticks_cfg = kpd_pkg::TICKS_RESET;

    logic [kpd_pkg::CODE_W-1:0]    scan_q [$];
    kpd_pkg::step_result_t         expected_q [$];
    kpd_pkg::step_result_t         want;

    int                            tx_gap = 0;
    int                            rx_gap = 0;
    bit                            tx_calm = 1'b0;
    bit                            rx_calm = 1'b0;
    int                            errors = 0;
    int                            cycles = 0;

    keypad_scan_debouncer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] scan_code
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [4:0] key_number, [6:5] debounce_phase
        .m_axis_tuser  (m_axis_tuser)    // key_event
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [kpd_pkg::KEY_W-1:0] key_of(
        input logic [kpd_pkg::CODE_W-1:0] code);
        logic [kpd_pkg::KEY_W-1:0] k;
        k = '0;
        if (code != kpd_pkg::CODE_NONE)
        begin
            for (int i = 0; i < kpd_pkg::KEY_COUNT; i++)
            begin
                if (kpd_pkg::CODE_TABLE[i] == code)
                begin
                    k = kpd_pkg::KEY_W'(i + 1);
                end
            end
        end
        return k;
    endfunction

    task automatic arm_hold();
        hold_on  = 1'b1;
        hold_cnt = ticks_cfg;
    endtask

    task automatic debounce_tick(input logic [kpd_pkg::CODE_W-1:0] code);
        logic [kpd_pkg::KEY_W-1:0] key;
        logic [kpd_pkg::KEY_W-1:0] rep;
        logic                      go;
        kpd_pkg::step_result_t     r;
        key = key_of(code);
        rep = '0;
        if (!hold_on)
        begin
            go = 1'b1;
        end
        else
        begin
            hold_cnt = hold_cnt - 1'b1;
            go = (hold_cnt == 0);
        end
        if (go)
        begin
            case (ph)
                kpd_pkg::PH_RELEASED:
                begin
                    if (key != 0)
                    begin
                        ph       = kpd_pkg::PH_UNKNOWN;
                        prior_ph = kpd_pkg::PH_RELEASED;
                        arm_hold();
                        cand_key = key;
                    end
                end
                kpd_pkg::PH_UNKNOWN:
                begin
                    if (key == 0)
                    begin
                        ph = kpd_pkg::PH_RELEASED;
                        if (prior_ph == kpd_pkg::PH_PUSHED)
                        begin
                            rep = cand_key;
                        end
                        prior_ph = kpd_pkg::PH_UNKNOWN;
                        hold_on  = 1'b0;
                    end
                    else if (key == cand_key)
                    begin
                        ph       = kpd_pkg::PH_PUSHED;
                        prior_ph = kpd_pkg::PH_UNKNOWN;
                        hold_on  = 1'b0;
                    end
                    else
                    begin
                        arm_hold();
                        cand_key = key;
                    end
                end
                kpd_pkg::PH_PUSHED:
                begin
                    if (key == 0)
                    begin
                        ph       = kpd_pkg::PH_UNKNOWN;
                        prior_ph = kpd_pkg::PH_PUSHED;
                        arm_hold();
                    end
                    else if (key != cand_key)
                    begin
                        // held key reported, prior forced to released
                        ph       = kpd_pkg::PH_UNKNOWN;
                        prior_ph = kpd_pkg::PH_RELEASED;
                        arm_hold();
                        rep      = cand_key;
                        cand_key = key;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.key_event  = (rep != 0);
        r.key_number = rep;
        r.phase      = ph;
        expected_q.push_back(r);
    endtask

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                debounce_tick(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (scan_q.size() > 0)
                begin
                    s_axis_tdata  <= scan_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    tx_gap = tx_calm ? 0 : $urandom_range(0, 6);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_axis_tuser !== want.key_event)
                    begin
                        errors++;
                        $display("%0t: key_event expected %0d actual %0d",
                                 $time, want.key_event, m_axis_tuser);
                    end
                    if (m_axis_tdata[4:0] !== want.key_number)
                    begin
                        errors++;
                        $display("%0t: key_number expected %0d actual %0d",
                                 $time, want.key_number, m_axis_tdata[4:0]);
                    end
                    if (m_axis_tdata[6:5] !== want.phase)
                    begin
                        errors++;
                        $display("%0t: debounce_phase expected %0d actual %0d",
                                 $time, want.phase, m_axis_tdata[6:5]);
                    end
                end
                rx_gap = rx_calm ? 0 : $urandom_range(0, 6);
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("keypad_scan_debouncer_tb: done, errors");
            $finish;
        end
    end

    // press length: mostly long enough to get through the hold-off
    function automatic int hold_len();
        int wait_len;
        wait_len = (ticks_cfg == 0) ? 256 : ticks_cfg;
        if ($urandom_range(0, 9) < 7)
        begin
            return wait_len + $urandom_range(1, 6);
        end
        return $urandom_range(1, wait_len);
    endfunction

    // level held for len ticks, with occasional bounce
    task automatic push_level(input logic [kpd_pkg::CODE_W-1:0] code, input int len,
                              inout int n);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 19))
                0:       scan_q.push_back(kpd_pkg::CODE_NONE);
                1:       scan_q.push_back(kpd_pkg::CODE_W'($urandom_range(0, 255)));
                2:       scan_q.push_back(
                             kpd_pkg::CODE_TABLE[$urandom_range(0, kpd_pkg::KEY_COUNT - 1)]);
                default: scan_q.push_back(code);
            endcase
        end
        n += len;
    endtask

    task automatic queue_strokes(input int budget);
        int                         n;
        int                         len;
        logic [kpd_pkg::CODE_W-1:0] code;
        n = 0;
        while (n < budget)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                begin
                    scan_q.push_back(kpd_pkg::CODE_W'($urandom_range(0, 255)));
                end
                n += len;
            end
            else
            begin
                code = kpd_pkg::CODE_TABLE[$urandom_range(0, kpd_pkg::KEY_COUNT - 1)];
                push_level(code, hold_len(), n);
                if ($urandom_range(0, 3) == 0)
                begin
                    code = kpd_pkg::CODE_TABLE[$urandom_range(0, kpd_pkg::KEY_COUNT - 1)];
                    push_level(code, hold_len(), n);
                end
                push_level(kpd_pkg::CODE_NONE, hold_len(), n);
            end
        end
    endtask

    task automatic settle();
        do
        begin
            @(posedge clk);
        end
        while (scan_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_ticks(input logic [kpd_pkg::TICKS_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        ticks_cfg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        queue_strokes(100);
        settle();

        write_ticks(8'd1);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        // release/push/key change/release-after-change, table ends, bad codes
        foreach (DIRECTED[i])
        begin
            scan_q.push_back(DIRECTED[i]);
        end
        queue_strokes(150);
        settle();

        write_ticks(8'd4);
        queue_strokes(100);
        settle();

        write_ticks(8'd255);
        queue_strokes(150);
        settle();

        // zero wraps to a 256-tick hold-off
        write_ticks(8'd0);
        queue_strokes(150);
        settle();

        if (errors == 0)
        begin
            $display("keypad_scan_debouncer_tb: done, clean");
        end
        else
        begin
            $display("keypad_scan_debouncer_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/kpd_pkg.sv
rtl/kpd_fsm.sv
rtl/keypad_scan_debouncer.sv
rtl/kpd_checker.sv
tb/keypad_scan_debouncer_tb.sv
